[sv/sdra_pkg.sv]
// Package for the density-rate accumulator: types, codes and arithmetic helpers.
package sdra_pkg;

   localparam int MaxParticles  = 1024;
   localparam int MaxDimensions = 3;

   typedef enum logic [1:0] {
      KIND_LOAD = 2'd0,
      KIND_PAIR = 2'd1,
      KIND_READ = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   localparam logic CSR_DIMENSIONS = 1'b0;
   localparam logic CSR_SLIP_MODE  = 1'b1;

   localparam logic [11:0] TYPE_FLUID_A = 12'd1;
   localparam logic [11:0] TYPE_FLUID_B = 12'd8;
   localparam logic [11:0] TYPE_GHOST   = 12'd1000;
   localparam logic [11:0] WALL_X0 = 12'd110;
   localparam logic [11:0] WALL_X1 = 12'd111;
   localparam logic [11:0] WALL_GX0 = 12'd1110;
   localparam logic [11:0] WALL_GX1 = 12'd1111;
   localparam logic [11:0] WALL_Y0 = 12'd220;
   localparam logic [11:0] WALL_Y1 = 12'd221;
   localparam logic [11:0] WALL_GY0 = 12'd2220;
   localparam logic [11:0] WALL_GY1 = 12'd2221;

   localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;
   localparam logic signed [49:0] TERM_LIM = 50'sd281474976710656;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic rd_a;       // read particle A stores
      logic rd_b;       // read particle B stores
      logic dot_clr;
      logic dot_step;   // accumulate one velocity component
      logic dot_done;   // clamp the dot product
      logic div_start;
      logic acc_a;      // write A's accumulator
      logic acc_b;      // write B's accumulator
      logic rd_mul;     // form the read product
      logic rsp_load;
      logic [1:0] comp;
      logic ghost;
   } cmd_type;

   // Status back to the controller
   typedef struct packed {
      logic fluid_a;
      logic fluid_b;
      logic ghost_b;
      logic wall_x;
      logic wall_y;
      logic wall_ghost;
      logic div_busy;
   } sts_type;

   function automatic logic is_fluid(input logic [11:0] t);
      return (t == TYPE_FLUID_A) || (t == TYPE_FLUID_B);
   endfunction

endpackage

[sv/sdra_if.sv]
// Valid/ready channel interfaces for requests, responses and register writes.
interface sdra_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [9:0]  index_a;
   logic [9:0]  index_b;
   logic signed [31:0] vec_x;
   logic signed [31:0] vec_y;
   logic signed [31:0] vec_z;
   logic signed [31:0] avg_x;
   logic signed [31:0] avg_y;
   logic signed [31:0] avg_z;
   logic [31:0] density;
   logic [31:0] particle_mass;
   logic [11:0] type_code;
   modport source (output valid, kind, index_a, index_b, vec_x, vec_y, vec_z,
                   avg_x, avg_y, avg_z, density, particle_mass, type_code, input ready);
   modport sink   (input valid, kind, index_a, index_b, vec_x, vec_y, vec_z,
                   avg_x, avg_y, avg_z, density, particle_mass, type_code, output ready);
endinterface

interface sdra_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] rate_out;
   logic        saturated;
   logic        zero_density;
   modport source (output valid, rate_out, saturated, zero_density, input ready);
   modport sink   (input valid, rate_out, saturated, zero_density, output ready);
endinterface

interface sdra_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[sv/sdra_divider.sv]
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module sdra_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] dividend,
   input  logic [31:0]        divisor,
   output logic               busy,
   output logic signed [63:0] quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dsr_ff;
   logic        neg_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic [33:0] trial;

   // Shift one dividend bit into the remainder and try a subtract
   always_comb begin
      trial  = {rem_ff, quo_ff[63]} - {2'b00, dsr_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (cnt_ff != 7'd0) begin
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= 7'd64;
      end else begin
         cnt_ff <= cnt_in;
      end
      if (start) begin
         quo_ff <= dividend[63] ? 64'(-dividend) : dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
         neg_ff <= dividend[63];
      end else begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = (cnt_ff != 7'd0);
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
endmodule

[sv/sdra_datapath.sv]
// Datapath: particle memories, dot-product unit, divider, accumulators and read path.
module sdra_datapath #(
   parameter int MAX_PARTICLES  = sdra_pkg::MaxParticles,
   parameter int MAX_DIMENSIONS = sdra_pkg::MaxDimensions
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_we,
   input  logic [9:0]        index_a,
   input  logic [9:0]        index_b,
   input  logic signed [31:0] vec [3],
   input  logic signed [31:0] avg [3],
   input  logic [31:0]       density,
   input  logic [31:0]       particle_mass,
   input  logic [11:0]       type_code,
   input  sdra_pkg::cmd_type cmd,
   output sdra_pkg::sts_type sts,
   output logic signed [31:0] rate_out,
   output logic              saturated,
   output logic              zero_density
);
   localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int DW = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;

   // One bank per velocity component
   logic signed [31:0] vel_mem [MAX_DIMENSIONS][MAX_PARTICLES];
   logic signed [31:0] avg_mem [MAX_DIMENSIONS][MAX_PARTICLES];
   logic [31:0] rho_mem [MAX_PARTICLES];
   logic [31:0] mass_mem [MAX_PARTICLES];
   logic [11:0] type_mem [MAX_PARTICLES];
   logic signed [47:0] acc_mem [MAX_PARTICLES];
   logic [1:0] flag_mem [MAX_PARTICLES];

   logic [IW-1:0] ia, ib;
   assign ia = IW'(index_a);
   assign ib = IW'(index_b);

   // Per-particle scalars latched by a read
   logic [31:0] rho_a_ff, rho_b_ff, mass_a_ff, mass_b_ff;
   logic [11:0] ta_ff, tb_ff;
   logic signed [47:0] acc_ff;
   logic [1:0]  flag_ff;
   logic signed [31:0] va_ff, vb_ff, aa_ff, grad_ff;
   logic signed [63:0] dot_ff;
   logic        sat_ff;
   logic signed [31:0] dotc_ff;

   // Indices and gradient held for the whole pair
   logic [IW-1:0] ia_ff, ib_ff;
   logic signed [31:0] gvec_ff [3];
   always_ff @(posedge clock) begin
      if (cmd.rd_a) begin
         ia_ff   <= ia;
         ib_ff   <= ib;
         gvec_ff <= vec;
      end
   end

   // Load writes, one entry per component bank
   always_ff @(posedge clock) begin
      if (load_we) begin
         for (int c = 0; c < MAX_DIMENSIONS; c++) begin
            vel_mem[c][ia] <= vec[c];
            avg_mem[c][ia] <= avg[c];
         end
         rho_mem[ia]  <= density;
         mass_mem[ia] <= particle_mass;
         type_mem[ia] <= type_code;
      end
   end

   // Scalar reads
   always_ff @(posedge clock) begin
      if (cmd.rd_a) begin
         rho_a_ff  <= rho_mem[ia];
         mass_a_ff <= mass_mem[ia];
         ta_ff     <= type_mem[ia];
      end
      if (cmd.rd_b) begin
         rho_b_ff  <= rho_mem[ib];
         mass_b_ff <= mass_mem[ib];
         tb_ff     <= type_mem[ib];
      end
   end

   // Per-component vector reads
   logic [DW-1:0] comp;
   assign comp = DW'(cmd.comp);
   always_ff @(posedge clock) begin
      va_ff   <= vel_mem[comp][ia_ff];
      vb_ff   <= vel_mem[comp][ib_ff];
      aa_ff   <= avg_mem[comp][ia_ff];
      grad_ff <= gvec_ff[cmd.comp];
   end

   // One component term
   logic signed [34:0] dv;
   logic signed [31:0] dvc;
   logic               dv_sat;
   logic signed [63:0] prod;
   logic signed [63:0] pterm;
   always_comb begin
      if (cmd.ghost)
         dv = 35'(va_ff) - (35'(vb_ff) * 35'sd2 - 35'(aa_ff));
      else
         dv = 35'(va_ff) - 35'(vb_ff);
      dv_sat = 1'b0;
      if (dv > 35'sd2147483647) begin
         dvc = 32'sh7FFF_FFFF; dv_sat = 1'b1;
      end else if (dv < -35'sd2147483648) begin
         dvc = 32'sh8000_0000; dv_sat = 1'b1;
      end else begin
         dvc = dv[31:0];
      end
      prod  = 64'(dvc) * 64'(grad_ff);
      pterm = (prod + (prod[63] ? 64'sd65535 : 64'sd0)) >>> 16;
   end

   // Dot-product register and its final clamp
   always_ff @(posedge clock) begin
      if (cmd.dot_clr) begin
         dot_ff <= '0;
         sat_ff <= 1'b0;
      end else if (cmd.dot_step) begin
         dot_ff <= dot_ff + pterm;
         sat_ff <= sat_ff | dv_sat;
      end else if (cmd.dot_done) begin
         if (dot_ff > 64'sd2147483647) begin
            dotc_ff <= 32'sh7FFF_FFFF; sat_ff <= 1'b1;
         end else if (dot_ff < -64'sd2147483648) begin
            dotc_ff <= 32'sh8000_0000; sat_ff <= 1'b1;
         end else begin
            dotc_ff <= dot_ff[31:0];
         end
      end
   end

   // Term dividend: mass * dot, registered before the divider
   logic signed [63:0] mdot_ff;
   logic               dst_b;
   assign dst_b = cmd.comp[0];
   always_ff @(posedge clock) begin
      mdot_ff <= 64'($signed({1'b0, (cmd.comp[0] ? mass_a_ff : mass_b_ff)})) * 64'(dotc_ff);
   end

   logic div_busy;
   logic signed [63:0] quo;
   sdra_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(mdot_ff),
      .divisor(cmd.comp[0] ? rho_a_ff : rho_b_ff),
      .busy(div_busy), .quotient(quo)
   );

   // Accumulator read-modify-write; the destination entry is registered before the write
   logic [IW-1:0] dst;
   logic [31:0]   drho;
   logic signed [47:0] accr_ff;
   logic [1:0]    flagr_ff;
   logic signed [63:0] t, sum;
   logic signed [47:0] nacc;
   logic          s;
   assign dst  = dst_b ? ib_ff : ia_ff;
   assign drho = dst_b ? rho_a_ff : rho_b_ff;
   always_comb begin
      s = sat_ff;
      t = quo;
      if (t > 64'(sdra_pkg::TERM_LIM)) begin t = 64'(sdra_pkg::TERM_LIM); s = 1'b1; end
      else if (t < -64'(sdra_pkg::TERM_LIM)) begin t = -64'(sdra_pkg::TERM_LIM); s = 1'b1; end
      sum = 64'(accr_ff) + t;
      if (sum > 64'(sdra_pkg::ACC_MAX)) begin nacc = sdra_pkg::ACC_MAX; s = 1'b1; end
      else if (sum < 64'(sdra_pkg::ACC_MIN)) begin nacc = sdra_pkg::ACC_MIN; s = 1'b1; end
      else nacc = sum[47:0];
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         acc_mem[ia]  <= '0;
         flag_mem[ia] <= 2'b00;
      end else if (cmd.acc_a || cmd.acc_b) begin
         if (drho == 32'd0) begin
            flag_mem[dst] <= flagr_ff | {1'b1, sat_ff};
         end else begin
            acc_mem[dst]  <= nacc;
            flag_mem[dst] <= flagr_ff | {1'b0, s};
         end
      end
      accr_ff  <= acc_mem[dst];
      flagr_ff <= flag_mem[dst];
      if (cmd.rd_a) begin
         acc_ff  <= acc_mem[ia];
         flag_ff <= flag_mem[ia];
      end
   end

   // Read product acc*rho as hi and lo halves
   logic signed [63:0] hi_ff, lo_ff, r;
   logic               rsat;
   always_ff @(posedge clock) begin
      if (cmd.rd_mul) begin
         hi_ff <= 64'(acc_ff) * 64'($signed({1'b0, rho_a_ff[31:16]}));
         lo_ff <= 64'(acc_ff) * 64'($signed({1'b0, rho_a_ff[15:0]}));
      end
   end
   logic signed [63:0] lo_t;
   always_comb begin
      lo_t = (lo_ff + (lo_ff[63] ? 64'sd65535 : 64'sd0)) >>> 16;
      r    = hi_ff + lo_t;
      rsat = (r > 64'sd2147483647) || (r < -64'sd2147483648);
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (cmd.ghost) begin
            rate_out <= '0; saturated <= 1'b0; zero_density <= 1'b0;
         end else begin
            rate_out <= rsat ? (r[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : r[31:0];
            saturated    <= flag_ff[0] | rsat;
            zero_density <= flag_ff[1];
         end
      end
   end

   always_comb begin
      sts.fluid_a    = sdra_pkg::is_fluid(ta_ff);
      sts.fluid_b    = sdra_pkg::is_fluid(tb_ff);
      sts.ghost_b    = (tb_ff >= sdra_pkg::TYPE_GHOST);
      sts.wall_x     = (tb_ff == sdra_pkg::WALL_X0) || (tb_ff == sdra_pkg::WALL_X1) ||
                       (tb_ff == sdra_pkg::WALL_GX0) || (tb_ff == sdra_pkg::WALL_GX1);
      sts.wall_y     = (tb_ff == sdra_pkg::WALL_Y0) || (tb_ff == sdra_pkg::WALL_Y1) ||
                       (tb_ff == sdra_pkg::WALL_GY0) || (tb_ff == sdra_pkg::WALL_GY1);
      sts.wall_ghost = (tb_ff == sdra_pkg::WALL_GX0) || (tb_ff == sdra_pkg::WALL_GX1) ||
                       (tb_ff == sdra_pkg::WALL_GY0) || (tb_ff == sdra_pkg::WALL_GY1);
      sts.div_busy   = div_busy;
   end
endmodule

[sv/sdra_ctrl.sv]
// Controller: sequences loads, pairs and reads over the datapath.
module sdra_ctrl #(
   parameter int MAX_PARTICLES  = sdra_pkg::MaxParticles,
   parameter int MAX_DIMENSIONS = sdra_pkg::MaxDimensions
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  logic [9:0]        req_index_a,
   input  logic [9:0]        req_index_b,
   input  logic [1:0]        dimensions,
   input  logic              slip_mode,
   input  sdra_pkg::sts_type sts,
   output sdra_pkg::cmd_type cmd,
   output logic              load_we,
   output logic              rsp_valid,
   input  logic              rsp_ready
);
   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_READ  = 13'b0000000000010,
      ST_DECIDE= 13'b0000000000100,
      ST_FETCH = 13'b0000000001000,
      ST_STEP  = 13'b0000000010000,
      ST_DOT   = 13'b0000000100000,
      ST_MULA  = 13'b0000001000000,
      ST_DIVA  = 13'b0000010000000,
      ST_ACCA  = 13'b0000100000000,
      ST_MULB  = 13'b0001000000000,
      ST_DIVB  = 13'b0010000000000,
      ST_ACCB  = 13'b0100000000000,
      ST_RDOUT = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] comp_ff, comp_in, last_ff, last_in;
   logic       ghost_ff, ghost_in, oob_ff, oob_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] dimn;
   logic       oob_a, oob_b;

   assign oob_a = 32'(req_index_a) >= MAX_PARTICLES;
   assign oob_b = 32'(req_index_b) >= MAX_PARTICLES;
   assign dimn  = (dimensions == 2'd0) ? 2'd1 :
                  (32'(dimensions) > MAX_DIMENSIONS) ? 2'(MAX_DIMENSIONS) : dimensions;

   // Ready whenever idle; a held response only stalls a later read in its output state
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff; comp_in = comp_ff; last_in = last_ff;
      ghost_in = ghost_ff; oob_in = oob_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0; load_we = 1'b0;
      cmd.comp  = comp_ff;
      cmd.ghost = ghost_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               case (req_kind)
                  sdra_pkg::KIND_LOAD: load_we = !oob_a;
                  sdra_pkg::KIND_PAIR: if (!oob_a && !oob_b) begin
                     cmd.rd_a = 1'b1; cmd.rd_b = 1'b1; state_in = ST_DECIDE;
                  end
                  sdra_pkg::KIND_READ: begin
                     cmd.rd_a = 1'b1; oob_in = oob_a; state_in = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            cmd.rd_mul = 1'b1; state_in = ST_RDOUT;
         end
         ST_RDOUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.ghost = oob_ff; cmd.rsp_load = 1'b1; rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DECIDE: begin
            cmd.dot_clr = 1'b1;
            if (!sts.fluid_a) begin
               state_in = ST_IDLE;
            end else if (!slip_mode || sts.fluid_b) begin
               comp_in = 2'd0; last_in = dimn - 2'd1; ghost_in = sts.ghost_b;
               state_in = ST_FETCH;
            end else if (sts.wall_x || (sts.wall_y && MAX_DIMENSIONS > 1)) begin
               comp_in = sts.wall_x ? 2'd0 : 2'd1; last_in = comp_in;
               ghost_in = sts.wall_ghost; state_in = ST_FETCH;
            end else begin
               state_in = ST_DOT;
            end
         end
         ST_FETCH: state_in = ST_STEP;
         ST_STEP: begin
            cmd.dot_step = 1'b1;
            if (comp_ff == last_ff) state_in = ST_DOT;
            else begin comp_in = comp_ff + 2'd1; state_in = ST_FETCH; end
         end
         ST_DOT: begin
            cmd.dot_done = 1'b1; state_in = ST_MULA;
         end
         ST_MULA: begin
            cmd.comp = 2'd0; state_in = ST_DIVA;
         end
         ST_DIVA: begin
            cmd.comp = 2'd0; cmd.div_start = 1'b1; state_in = ST_ACCA;
         end
         ST_ACCA: begin
            cmd.comp = 2'd0;
            if (!sts.div_busy) begin
               cmd.acc_a = 1'b1;
               state_in = sts.fluid_b ? ST_MULB : ST_IDLE;
            end
         end
         ST_MULB: begin
            cmd.comp = 2'd1; state_in = ST_DIVB;
         end
         ST_DIVB: begin
            cmd.comp = 2'd1; cmd.div_start = 1'b1; state_in = ST_ACCB;
         end
         ST_ACCB: begin
            cmd.comp = 2'd1;
            if (!sts.div_busy) begin
               cmd.acc_b = 1'b1; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rsp_valid_ff <= 1'b0;
         comp_ff <= '0; last_ff <= '0; ghost_ff <= 1'b0;
         oob_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rsp_valid_ff <= rsp_valid_in;
         comp_ff <= comp_in; last_ff <= last_in; ghost_ff <= ghost_in;
         oob_ff <= oob_in;
      end
   end

   // The divider never runs while the accumulator is written
   a_no_acc_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.acc_a || cmd.acc_b) |-> !sts.div_busy) else $error("accumulate while dividing");
   // A response is raised only from the read output state
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RDOUT) else $error("stray response");
   // A held response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.rsp_load) else $error("response overwritten");
endmodule

[sv/sph_density_rate_accumulator.sv]
// Top level of the density-rate accumulator: channels, registers, controller, datapath.
// Load: 1 cycle. Read: 3 cycles to a registered result, held until transferred; a later
// read waits in its output state while that result is held, loads and pairs do not.
// Pair: 3 + 2 per velocity component used + 67 per division (one or two), set by the
// bit-serial divider; a non-fluid A ends after 2. One item is in flight at a time.
// Reset (synchronous, active high) sets dimensions to 2 and slip mode off; particle
// memories are undefined until loaded and need no clearing pass.
module sph_density_rate_accumulator #(
   parameter int MAX_PARTICLES  = sdra_pkg::MaxParticles,
   parameter int MAX_DIMENSIONS = sdra_pkg::MaxDimensions
) (
   input logic clock,
   input logic reset,
   sdra_req_if.sink   req,
   sdra_rsp_if.source rsp,
   sdra_csr_if.sink   csr
);
   logic [1:0] dimensions_ff;
   logic       slip_mode_ff;
   sdra_pkg::cmd_type cmd;
   sdra_pkg::sts_type sts;
   logic load_we;
   logic signed [31:0] vec [3];
   logic signed [31:0] avg [3];

   assign vec[0] = req.vec_x; assign vec[1] = req.vec_y; assign vec[2] = req.vec_z;
   assign avg[0] = req.avg_x; assign avg[1] = req.avg_y; assign avg[2] = req.avg_z;

   // Register writes
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         dimensions_ff <= 2'd2;
         slip_mode_ff  <= 1'b0;
      end else if (csr.valid) begin
         case (csr.index)
            sdra_pkg::CSR_DIMENSIONS: dimensions_ff <= csr.data;
            sdra_pkg::CSR_SLIP_MODE:  slip_mode_ff  <= csr.data[0];
            default: ;
         endcase
      end
   end

   sdra_ctrl #(.MAX_PARTICLES(MAX_PARTICLES), .MAX_DIMENSIONS(MAX_DIMENSIONS)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_kind(req.kind),
      .req_index_a(req.index_a), .req_index_b(req.index_b),
      .dimensions(dimensions_ff), .slip_mode(slip_mode_ff),
      .sts(sts), .cmd(cmd), .load_we(load_we),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready)
   );

   sdra_datapath #(.MAX_PARTICLES(MAX_PARTICLES), .MAX_DIMENSIONS(MAX_DIMENSIONS)) u_dp (
      .clock(clock), .reset(reset), .load_we(load_we),
      .index_a(req.index_a), .index_b(req.index_b), .vec(vec), .avg(avg),
      .density(req.density), .particle_mass(req.particle_mass), .type_code(req.type_code),
      .cmd(cmd), .sts(sts),
      .rate_out(rsp.rate_out), .saturated(rsp.saturated), .zero_density(rsp.zero_density)
   );
endmodule

[bench/tb_sph_density_rate_accumulator.sv]
// Self-checking testbench for the density-rate accumulator: queued stimulus, scoreboard.
`timescale 1ns / 1ps

module tb_sph_density_rate_accumulator;

   localparam int HANG_LIMIT = 5000;   // cycles without any transfer
   localparam int SETTLE     = 250;    // longer than a pair with two divisions

   typedef struct {
      sdra_pkg::kind_type kind;
      logic [9:0]  a;
      logic [9:0]  b;
      logic [31:0] vec [3];
      logic [31:0] avg [3];
      logic [31:0] dens;
      logic [31:0] mass;
      logic [11:0] ptype;
   } job_type;

   typedef struct {
      logic [31:0] rate;
      logic        sat;
      logic        zero;
   } rate_type;

   logic clock;
   logic reset;

   sdra_req_if req ();
   sdra_rsp_if rsp ();
   sdra_csr_if csr ();

   sph_density_rate_accumulator DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   // particle table of the predictor
   longint      vel_tab  [1024][3];
   longint      avg_tab  [1024][3];
   logic [31:0] dens_tab [1024];
   logic [31:0] mass_tab [1024];
   logic [11:0] type_tab [1024];
   longint      acc_tab  [1024];
   logic        sat_tab  [1024];
   logic        zero_tab [1024];
   int          n_dims;
   bit          slip_on;

   job_type  job_queue [$];
   rate_type rate_expected [$];
   job_type  held, nxt;
   int    errors = 0;
   int    send_idle = 0;
   int    recv_stall = 0;
   int    quiet = 0;

   // generation side bookkeeping
   bit          loaded [1024];
   logic [9:0]  loaded_list [$];
   logic [9:0]  work_set [24];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp(longint v, longint lo, longint hi, inout bit s);
      if (v < lo) begin
         s = 1'b1;
         return lo;
      end
      if (v > hi) begin
         s = 1'b1;
         return hi;
      end
      return v;
   endfunction

   // one component of (vA - vB') * grad in Q16.16
   function automatic longint comp_product(int a, int b, int c, bit ghost, longint grad,
                                           inout bit s);
      longint d;
      if (ghost) d = vel_tab[a][c] - (2 * vel_tab[b][c] - avg_tab[a][c]);
      else       d = vel_tab[a][c] - vel_tab[b][c];
      d = clamp(d, -64'sd2147483648, 64'sd2147483647, s);
      return (d * grad) / 65536;
   endfunction

   function automatic void add_term(int dst, logic [31:0] m, logic [31:0] rho, longint dot,
                                    bit s_in);
      bit     s;
      longint t;
      s = s_in;
      if (rho == 0) begin
         zero_tab[dst] = 1'b1;
      end else begin
         t = (longint'({32'd0, m}) * dot) / longint'({32'd0, rho});
         t = clamp(t, -longint'(sdra_pkg::TERM_LIM), longint'(sdra_pkg::TERM_LIM), s);
         acc_tab[dst] = clamp(acc_tab[dst] + t, longint'(sdra_pkg::ACC_MIN),
                              longint'(sdra_pkg::ACC_MAX), s);
      end
      if (s) sat_tab[dst] = 1'b1;
   endfunction

   // apply one accepted request to the table, queueing a read result
   function automatic void apply_job(job_type j);
      int     a, b, n, comp;
      bit     s, ghost;
      longint dot, hi, lo, r;
      logic [11:0] tb_t;
      rate_type e;
      a = j.a;
      b = j.b;
      s = 1'b0;
      dot = 0;
      case (j.kind)
         sdra_pkg::KIND_LOAD: begin
            for (int c = 0; c < 3; c++) begin
               vel_tab[a][c] = longint'(signed'(j.vec[c]));
               avg_tab[a][c] = longint'(signed'(j.avg[c]));
            end
            dens_tab[a] = j.dens;
            mass_tab[a] = j.mass;
            type_tab[a] = j.ptype;
            acc_tab[a]  = 0;
            sat_tab[a]  = 1'b0;
            zero_tab[a] = 1'b0;
         end
         sdra_pkg::KIND_PAIR: begin
            tb_t = type_tab[b];
            if (sdra_pkg::is_fluid(type_tab[a])) begin
               if (!slip_on || sdra_pkg::is_fluid(tb_t)) begin
                  n = (n_dims == 0) ? 1 : n_dims;
                  for (int c = 0; c < n; c++)
                     dot += comp_product(a, b, c, tb_t >= sdra_pkg::TYPE_GHOST,
                                         longint'(signed'(j.vec[c])), s);
               end else begin
                  comp = -1;
                  ghost = 1'b0;
                  if (tb_t == sdra_pkg::WALL_X0 || tb_t == sdra_pkg::WALL_X1) comp = 0;
                  else if (tb_t == sdra_pkg::WALL_GX0 || tb_t == sdra_pkg::WALL_GX1) begin
                     comp = 0;
                     ghost = 1'b1;
                  end else if (tb_t == sdra_pkg::WALL_Y0 || tb_t == sdra_pkg::WALL_Y1) begin
                     comp = 1;
                  end else if (tb_t == sdra_pkg::WALL_GY0 || tb_t == sdra_pkg::WALL_GY1) begin
                     comp = 1;
                     ghost = 1'b1;
                  end
                  if (comp >= 0)
                     dot = comp_product(a, b, comp, ghost,
                                        longint'(signed'(j.vec[comp])), s);
               end
               dot = clamp(dot, -64'sd2147483648, 64'sd2147483647, s);
               add_term(a, mass_tab[b], dens_tab[b], dot, s);
               if (sdra_pkg::is_fluid(tb_t)) add_term(b, mass_tab[a], dens_tab[a], dot, s);
            end
         end
         sdra_pkg::KIND_READ: begin
            hi = acc_tab[a] * longint'({48'd0, dens_tab[a][31:16]});
            lo = (acc_tab[a] * longint'({48'd0, dens_tab[a][15:0]})) / 65536;
            r = clamp(hi + lo, -64'sd2147483648, 64'sd2147483647, s);
            e.rate = r[31:0];
            e.sat  = sat_tab[a] | s;
            e.zero = zero_tab[a];
            rate_expected.push_back(e);
         end
         default: ;
      endcase
   endfunction

   // field values with the extremes well represented
   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'hFFFF_FFFF;
         4, 5: return 32'($signed($urandom_range(262144)) - 131072);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_density();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2, 3: return 32'h0001_0000;
         4: return $urandom;
         default: return $urandom_range(32'h0004_0000, 1);
      endcase
   endfunction

   function automatic logic [11:0] pick_type();
      case ($urandom_range(15))
         0, 1, 2, 3: return sdra_pkg::TYPE_FLUID_A;
         4, 5, 6: return sdra_pkg::TYPE_FLUID_B;
         7: return ($urandom_range(1)) ? sdra_pkg::WALL_X0 : sdra_pkg::WALL_X1;
         8: return ($urandom_range(1)) ? sdra_pkg::WALL_Y0 : sdra_pkg::WALL_Y1;
         9: return ($urandom_range(1)) ? sdra_pkg::WALL_GX0 : sdra_pkg::WALL_GX1;
         10: return ($urandom_range(1)) ? sdra_pkg::WALL_GY0 : sdra_pkg::WALL_GY1;
         11: return sdra_pkg::TYPE_GHOST + 12'($urandom_range(8));
         12: return 12'hFFF;
         default: return 12'($urandom_range(4095));
      endcase
   endfunction

   function automatic job_type blank_job(sdra_pkg::kind_type k, logic [9:0] a, logic [9:0] b);
      job_type j;
      j.kind = k;
      j.a = a;
      j.b = b;
      for (int c = 0; c < 3; c++) begin
         j.vec[c] = pick_word();
         j.avg[c] = pick_word();
      end
      j.dens  = pick_density();
      j.mass  = pick_density();
      j.ptype = pick_type();
      return j;
   endfunction

   task automatic queue_load(logic [9:0] idx, logic [11:0] t, logic [31:0] rho);
      job_type j;
      j = blank_job(sdra_pkg::KIND_LOAD, idx, 10'($urandom));
      j.ptype = t;
      j.dens = rho;
      job_queue.push_back(j);
      if (!loaded[idx]) begin
         loaded[idx] = 1'b1;
         loaded_list.push_back(idx);
      end
   endtask

   function automatic logic [9:0] any_loaded();
      return loaded_list[$urandom_range(loaded_list.size() - 1)];
   endfunction

   task automatic queue_random();
      int roll;
      logic [9:0] idx;
      roll = $urandom_range(99);
      if (roll < 22) begin
         idx = ($urandom_range(9) < 7) ? work_set[$urandom_range(23)] : 10'($urandom);
         queue_load(idx, pick_type(), pick_density());
      end else if (roll < 74) begin
         job_queue.push_back(blank_job(sdra_pkg::KIND_PAIR, any_loaded(), any_loaded()));
      end else if (roll < 96) begin
         job_queue.push_back(blank_job(sdra_pkg::KIND_READ, any_loaded(), 10'($urandom)));
      end else begin
         job_queue.push_back(blank_job(sdra_pkg::KIND_NONE, 10'($urandom), 10'($urandom)));
      end
   endtask

   // register write through the CSR channel; the predictor follows on transfer
   task automatic write_reg(logic idx, logic [1:0] val);
      @(posedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= val;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      if (idx == sdra_pkg::CSR_DIMENSIONS) n_dims = val;
      else                                 slip_on = val[0];
   endtask

   task automatic drain();
      while (job_queue.size() != 0 || req.valid || rate_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (job_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
            nxt = job_queue.pop_front();
            req.valid <= 1'b1;
            req.kind <= nxt.kind;
            req.index_a <= nxt.a;
            req.index_b <= nxt.b;
            req.vec_x <= nxt.vec[0];
            req.vec_y <= nxt.vec[1];
            req.vec_z <= nxt.vec[2];
            req.avg_x <= nxt.avg[0];
            req.avg_y <= nxt.avg[1];
            req.avg_z <= nxt.avg[2];
            req.density <= nxt.dens;
            req.particle_mass <= nxt.mass;
            req.type_code <= nxt.ptype;
            held <= nxt;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // predict on request transfer, check on response transfer
   always @(posedge clock) begin
      if (!reset) begin
         rsp.ready <= ($urandom_range(99) >= recv_stall);
         if (req.valid && req.ready) apply_job(held);
         if (rsp.valid && rsp.ready) begin
            if (rate_expected.size() == 0) begin
               errors++;
               $display("%0t: unexpected response rate=%h sat=%b zero=%b", $time,
                        rsp.rate_out, rsp.saturated, rsp.zero_density);
            end else begin
               if (rsp.rate_out !== rate_expected[0].rate) begin
                  errors++;
                  $display("%0t: rate_out expected %h actual %h", $time,
                           rate_expected[0].rate, rsp.rate_out);
               end
               if (rsp.saturated !== rate_expected[0].sat) begin
                  errors++;
                  $display("%0t: saturated expected %b actual %b", $time,
                           rate_expected[0].sat, rsp.saturated);
               end
               if (rsp.zero_density !== rate_expected[0].zero) begin
                  errors++;
                  $display("%0t: zero_density expected %b actual %b", $time,
                           rate_expected[0].zero, rsp.zero_density);
               end
               void'(rate_expected.pop_front());
            end
         end
      end
   end

   // watchdog on any transfer
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= HANG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      logic [11:0] codes [12];
      int dims_seq [4];
      int idle_seq [4];
      int stall_seq [4];
      codes = '{sdra_pkg::TYPE_FLUID_A, sdra_pkg::TYPE_FLUID_B, sdra_pkg::WALL_X0,
                sdra_pkg::WALL_X1, sdra_pkg::WALL_Y0, sdra_pkg::WALL_Y1,
                sdra_pkg::WALL_GX0, sdra_pkg::WALL_GX1, sdra_pkg::WALL_GY0,
                sdra_pkg::WALL_GY1, sdra_pkg::TYPE_GHOST, 12'hFFF};
      dims_seq  = '{3, 1, 0, 2};
      idle_seq  = '{0, 85, 0, 7};
      stall_seq = '{0, 0, 85, 7};
      n_dims = 2;
      slip_on = 1'b0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.kind = sdra_pkg::KIND_NONE;
      req.index_a = '0;
      req.index_b = '0;
      req.vec_x = '0;
      req.vec_y = '0;
      req.vec_z = '0;
      req.avg_x = '0;
      req.avg_y = '0;
      req.avg_z = '0;
      req.density = '0;
      req.particle_mass = '0;
      req.type_code = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = sdra_pkg::CSR_DIMENSIONS;
      csr.data = '0;
      for (int i = 0; i < 24; i++) work_set[i] = 10'($urandom);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes of index, every type code, zero density, both slip modes
      queue_load(10'd0, sdra_pkg::TYPE_FLUID_A, 32'h0001_0000);
      queue_load(10'd1023, sdra_pkg::TYPE_FLUID_B, 32'hFFFF_FFFF);
      queue_load(10'd5, sdra_pkg::TYPE_FLUID_A, 32'h0000_0000);
      for (int i = 0; i < 12; i++) queue_load(10'(100 + i), codes[i], pick_density());
      job_queue.push_back(blank_job(sdra_pkg::KIND_PAIR, 10'd0, 10'd1023));
      job_queue.push_back(blank_job(sdra_pkg::KIND_PAIR, 10'd1023, 10'd5));
      job_queue.push_back(blank_job(sdra_pkg::KIND_PAIR, 10'd102, 10'd0));
      for (int i = 2; i < 12; i++)
         job_queue.push_back(blank_job(sdra_pkg::KIND_PAIR, 10'd0, 10'(100 + i)));
      job_queue.push_back(blank_job(sdra_pkg::KIND_NONE, 10'd1023, 10'd1023));
      job_queue.push_back(blank_job(sdra_pkg::KIND_READ, 10'd0, 10'd0));
      job_queue.push_back(blank_job(sdra_pkg::KIND_READ, 10'd1023, 10'd0));
      job_queue.push_back(blank_job(sdra_pkg::KIND_READ, 10'd5, 10'd0));
      drain();
      write_reg(sdra_pkg::CSR_SLIP_MODE, 2'd1);
      for (int i = 2; i < 12; i++)
         job_queue.push_back(blank_job(sdra_pkg::KIND_PAIR, 10'd1023, 10'(100 + i)));
      job_queue.push_back(blank_job(sdra_pkg::KIND_READ, 10'd1023, 10'd0));
      drain();

      // random phases over idling patterns and register settings
      for (int p = 0; p < 4; p++) begin
         write_reg(sdra_pkg::CSR_DIMENSIONS, 2'(dims_seq[p]));
         write_reg(sdra_pkg::CSR_SLIP_MODE, 2'(p % 2));
         send_idle = idle_seq[p];
         recv_stall = stall_seq[p];
         for (int i = 0; i < 170; i++) queue_random();
         drain();
      end

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
